// ----- hw/rtl/lrf_pkg.sv -----
package lrf_pkg;

  localparam int MAX_PATTERN_BYTES_DEF = 48;
  localparam int PATTERN_WORDS = 6;
  localparam int PATTERN_BYTES = PATTERN_WORDS * 8;
  localparam int CFG_INDEX_W = 3;
  localparam int CFG_DATA_W = 64;
  localparam int LEN_W = 6;

  localparam logic [7:0] CH_CARET   = 8'h5E;
  localparam logic [7:0] CH_DOLLAR  = 8'h24;
  localparam logic [7:0] CH_DOT     = 8'h2E;
  localparam logic [7:0] CH_STAR    = 8'h2A;
  localparam logic [7:0] CH_NEWLINE = 8'h0A;
  localparam logic [7:0] CH_NUL     = 8'h00;

  typedef enum logic [2:0] {
    REG_PATTERN_WORD_0,
    REG_PATTERN_WORD_1,
    REG_PATTERN_WORD_2,
    REG_PATTERN_WORD_3,
    REG_PATTERN_WORD_4,
    REG_PATTERN_WORD_5,
    REG_PATTERN_LENGTH,
    REG_INVERT_SELECTION
  } cfg_reg_t;

  typedef enum logic [2:0] {
    TK_LIT,
    TK_ANY,
    TK_STAR_LIT,
    TK_STAR_ANY,
    TK_END
  } token_kind_t;

  typedef enum logic [1:0] {
    BC_TEXT,
    BC_NUL,
    BC_NEWLINE
  } byte_class_t;

  typedef enum logic [1:0] {
    PS_IDLE,
    PS_LOAD,
    PS_PARSE
  } parse_state_t;

  typedef struct packed {
    byte_class_t cls;
    logic [7:0]  data;
  } text_item_t;

  typedef struct packed {
    logic line_selected;
    logic pattern_matched;
    logic cut_by_nul;
  } result_t;

endpackage

// ----- hw/rtl/line_regex_filter_core.sv -----
// Line filter with a small regex matcher. Text bytes go in on push/full, one
// result per newline comes out on empty/pop: the match after the optional
// inversion, the raw match, and whether a NUL cut the line. A line without a
// final newline gives no result. The matcher is a position-vector NFA that
// takes one byte per cycle while the result queue has room and no write is
// being tokenized. The user must write pattern bytes, length and inversion
// on the cfg port only while no line is in progress; the block does not
// enforce this. Every write restarts a tokenizer that walks the pattern one
// token per cycle; full stays high from the write until it finishes.
module line_regex_filter_core
  import lrf_pkg::*;
#(
  parameter int MAX_PATTERN_BYTES = MAX_PATTERN_BYTES_DEF
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   push,
  output logic                   full,
  input  logic [7:0]             text_byte,
  output logic                   empty,
  input  logic                   pop,
  output logic                   line_selected,
  output logic                   pattern_matched,
  output logic                   cut_by_nul,
  input  logic                   cfg_write,
  input  logic [CFG_INDEX_W-1:0] cfg_index,
  input  logic [CFG_DATA_W-1:0]  cfg_data
);

  logic                                busy;
  logic                                invert;
  logic                                anchored;
  token_kind_t [MAX_PATTERN_BYTES-1:0] tok_kind;
  logic [MAX_PATTERN_BYTES-1:0][7:0]   tok_char;
  logic [MAX_PATTERN_BYTES-1:0]        tok_live;
  logic [MAX_PATTERN_BYTES:0]          fin_mask;
  logic [MAX_PATTERN_BYTES:0]          end_mask;

  logic       item_valid;
  logic       item_take;
  text_item_t item;

  lrf_cfg #(
    .MAXP(MAX_PATTERN_BYTES)
  ) u_cfg (
    .clk      (clk),
    .rst      (rst),
    .cfg_write(cfg_write),
    .cfg_index(cfg_index),
    .cfg_data (cfg_data),
    .busy     (busy),
    .invert   (invert),
    .anchored (anchored),
    .tok_kind (tok_kind),
    .tok_char (tok_char),
    .tok_live (tok_live),
    .fin_mask (fin_mask),
    .end_mask (end_mask)
  );

  lrf_front u_front (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .text_byte (text_byte),
    .hold      (busy || cfg_write),
    .full      (full),
    .item_valid(item_valid),
    .item      (item),
    .item_take (item_take)
  );

  lrf_match #(
    .MAXP(MAX_PATTERN_BYTES)
  ) u_match (
    .clk            (clk),
    .rst            (rst),
    .item_valid     (item_valid),
    .item           (item),
    .item_take      (item_take),
    .invert         (invert),
    .anchored       (anchored),
    .tok_kind       (tok_kind),
    .tok_char       (tok_char),
    .tok_live       (tok_live),
    .fin_mask       (fin_mask),
    .end_mask       (end_mask),
    .pop            (pop),
    .empty          (empty),
    .line_selected  (line_selected),
    .pattern_matched(pattern_matched),
    .cut_by_nul     (cut_by_nul)
  );

endmodule

// ----- hw/rtl/lrf_cfg.sv -----
module lrf_cfg
  import lrf_pkg::*;
#(
  parameter int MAXP = MAX_PATTERN_BYTES_DEF
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          cfg_write,
  input  logic [CFG_INDEX_W-1:0]        cfg_index,
  input  logic [CFG_DATA_W-1:0]         cfg_data,
  output logic                          busy,
  output logic                          invert,
  output logic                          anchored,
  output token_kind_t [MAXP-1:0]        tok_kind,
  output logic [MAXP-1:0][7:0]          tok_char,
  output logic [MAXP-1:0]               tok_live,
  output logic [MAXP:0]                 fin_mask,
  output logic [MAXP:0]                 end_mask
);

  localparam int BUF_N = (MAXP < 2) ? 2 : MAXP;
  localparam int CNT_W = $clog2(MAXP + 1);

  logic [PATTERN_WORDS-1:0][CFG_DATA_W-1:0] pattern_word;
  logic [LEN_W-1:0]      pattern_length;
  logic [LEN_W-1:0]      len_sat;
  logic [PATTERN_BYTES-1:0][7:0] pat_bytes;
  logic                  anchored_next;

  parse_state_t          pstate, pstate_next;
  logic [BUF_N-1:0][7:0] buf_q;
  logic [LEN_W-1:0]      rem;
  logic [CNT_W-1:0]      n;
  logic                  last_end;

  logic                  cur_ok, nxt_ok, two_step;
  token_kind_t           kind_new;

  always_ff @(posedge clk) begin
    if (rst) begin
      pattern_word   <= '0;
      pattern_length <= '0;
      invert         <= 1'b0;
    end else if (cfg_write) begin
      case (cfg_reg_t'(cfg_index))
        REG_PATTERN_WORD_0: pattern_word[0] <= cfg_data;
        REG_PATTERN_WORD_1: pattern_word[1] <= cfg_data;
        REG_PATTERN_WORD_2: pattern_word[2] <= cfg_data;
        REG_PATTERN_WORD_3: pattern_word[3] <= cfg_data;
        REG_PATTERN_WORD_4: pattern_word[4] <= cfg_data;
        REG_PATTERN_WORD_5: pattern_word[5] <= cfg_data;
        REG_PATTERN_LENGTH: pattern_length <= cfg_data[LEN_W-1:0];
        REG_INVERT_SELECTION: invert <= cfg_data[0];
        default: ;
      endcase
    end
  end

  assign pat_bytes = pattern_word;
  assign len_sat = (pattern_length > LEN_W'(MAXP)) ? LEN_W'(MAXP) : pattern_length;
  assign anchored_next = (len_sat != '0) && (pat_bytes[0] == CH_CARET);

  assign cur_ok   = (rem != '0) && (buf_q[0] != CH_NUL);
  assign nxt_ok   = (rem > LEN_W'(1)) && (buf_q[1] != CH_NUL);
  assign two_step = nxt_ok && (buf_q[1] == CH_STAR);

  always_comb begin
    if (two_step) begin
      kind_new = (buf_q[0] == CH_DOT) ? TK_STAR_ANY : TK_STAR_LIT;
    end else if (buf_q[0] == CH_DOLLAR && !nxt_ok) begin
      kind_new = TK_END;
    end else begin
      kind_new = (buf_q[0] == CH_DOT) ? TK_ANY : TK_LIT;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pstate <= PS_IDLE;
    end else begin
      pstate <= pstate_next;
    end
  end

  always_comb begin
    pstate_next = pstate;
    if (cfg_write) begin
      pstate_next = PS_LOAD;
    end else begin
      case (pstate)
        PS_IDLE:  pstate_next = PS_IDLE;
        PS_LOAD:  pstate_next = PS_PARSE;
        PS_PARSE: pstate_next = cur_ok ? PS_PARSE : PS_IDLE;
        default:  pstate_next = PS_IDLE;
      endcase
    end
  end

  assign busy = (pstate != PS_IDLE);

  // tokenizer: one token per cycle from a shifting byte window
  always_ff @(posedge clk) begin
    if (rst) begin
      anchored <= 1'b0;
      tok_live <= '0;
      fin_mask <= (MAXP + 1)'(1);
      end_mask <= '0;
      n        <= '0;
      last_end <= 1'b0;
      rem      <= '0;
    end else if (pstate == PS_LOAD) begin
      anchored <= anchored_next;
      tok_live <= '0;
      n        <= '0;
      last_end <= 1'b0;
      rem      <= len_sat - LEN_W'(anchored_next);
      buf_q    <= (BUF_N * 8)'(anchored_next ? (pat_bytes >> 8) : pat_bytes);
    end else if (pstate == PS_PARSE) begin
      if (cur_ok) begin
        for (int k = 0; k < MAXP; k++) begin
          if (n == CNT_W'(k)) begin
            tok_kind[k] <= kind_new;
            tok_char[k] <= buf_q[0];
            tok_live[k] <= 1'b1;
          end
        end
        n        <= n + CNT_W'(1);
        last_end <= (kind_new == TK_END);
        if (two_step) begin
          rem   <= rem - LEN_W'(2);
          buf_q <= buf_q >> 16;
        end else begin
          rem   <= rem - LEN_W'(1);
          buf_q <= buf_q >> 8;
        end
      end else begin
        for (int k = 0; k <= MAXP; k++) begin
          fin_mask[k] <= (n == CNT_W'(k));
          end_mask[k] <= last_end && (n == CNT_W'(k + 1));
        end
      end
    end
  end

endmodule

// ----- hw/rtl/lrf_front.sv -----
module lrf_front
  import lrf_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  logic       push,
  input  logic [7:0] text_byte,
  input  logic       hold,
  output logic       full,
  output logic       item_valid,
  output text_item_t item,
  input  logic       item_take
);

  text_item_t       mem [2];
  logic             wr_ptr, rd_ptr;
  logic [1:0]       count;
  logic             accept;
  text_item_t       item_in;

  assign full   = (count == 2'd2) || hold;
  assign accept = push && !full;

  always_comb begin
    item_in.data = text_byte;
    if (text_byte == CH_NEWLINE) begin
      item_in.cls = BC_NEWLINE;
    end else if (text_byte == CH_NUL) begin
      item_in.cls = BC_NUL;
    end else begin
      item_in.cls = BC_TEXT;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      mem[wr_ptr] <= item_in;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= '0;
    end else begin
      if (accept) begin
        wr_ptr <= !wr_ptr;
      end
      if (item_take) begin
        rd_ptr <= !rd_ptr;
      end
      case ({accept, item_take})
        2'b10:   count <= count + 2'd1;
        2'b01:   count <= count - 2'd1;
        default: count <= count;
      endcase
    end
  end

  assign item_valid = (count != '0);
  assign item       = mem[rd_ptr];

endmodule

// ----- hw/rtl/lrf_match.sv -----
module lrf_match
  import lrf_pkg::*;
#(
  parameter int MAXP = MAX_PATTERN_BYTES_DEF
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   item_valid,
  input  text_item_t             item,
  output logic                   item_take,
  input  logic                   invert,
  input  logic                   anchored,
  input  token_kind_t [MAXP-1:0] tok_kind,
  input  logic [MAXP-1:0][7:0]   tok_char,
  input  logic [MAXP-1:0]        tok_live,
  input  logic [MAXP:0]          fin_mask,
  input  logic [MAXP:0]          end_mask,
  input  logic                   pop,
  output logic                   empty,
  output logic                   line_selected,
  output logic                   pattern_matched,
  output logic                   cut_by_nul
);

  localparam int KS_LVL = $clog2(MAXP + 1);

  logic [MAXP:0] active;
  logic          has_match, text_cut, chars_seen;

  logic [MAXP:0] seed, gen, prop, cur, adv;
  logic          fin_hit, line_hit;

  result_t       rmem [2];
  logic          rwr_ptr, rrd_ptr;
  logic [1:0]    rcount;
  logic          rpush, rpop;
  result_t       res_in, res_out;

  assign item_take = item_valid && (rcount != 2'd2);

  // epsilon closure over star tokens as a prefix network, then one byte step
  always_comb begin
    seed = active;
    if (!anchored || !chars_seen) begin
      seed[0] = 1'b1;
    end
    prop = '0;
    for (int k = 0; k < MAXP; k++) begin
      prop[k + 1] = tok_live[k] &&
                    (tok_kind[k] == TK_STAR_LIT || tok_kind[k] == TK_STAR_ANY);
    end
    gen = seed;
    for (int l = 0; l < KS_LVL; l++) begin
      gen  = gen | (prop & (gen << (1 << l)));
      prop = prop & (prop << (1 << l));
    end
    cur = gen;
    adv = '0;
    for (int k = 0; k < MAXP; k++) begin
      if (cur[k] && tok_live[k]) begin
        case (tok_kind[k])
          TK_LIT:      if (tok_char[k] == item.data) adv[k + 1] = 1'b1;
          TK_ANY:      adv[k + 1] = 1'b1;
          TK_STAR_LIT: if (tok_char[k] == item.data) adv[k] = 1'b1;
          TK_STAR_ANY: adv[k] = 1'b1;
          default:     ;
        endcase
      end
    end
  end

  assign fin_hit  = |(cur & fin_mask);
  assign line_hit = has_match || fin_hit || (|(cur & end_mask));

  always_ff @(posedge clk) begin
    if (rst) begin
      active     <= '0;
      has_match  <= 1'b0;
      text_cut   <= 1'b0;
      chars_seen <= 1'b0;
    end else if (item_take) begin
      case (item.cls)
        BC_NEWLINE: begin
          active     <= '0;
          has_match  <= 1'b0;
          text_cut   <= 1'b0;
          chars_seen <= 1'b0;
        end
        BC_NUL: begin
          text_cut <= 1'b1;
        end
        default: begin
          if (!text_cut) begin
            if (fin_hit) begin
              has_match <= 1'b1;
            end
            active     <= adv;
            chars_seen <= 1'b1;
          end
        end
      endcase
    end
  end

  // result queue
  assign rpush = item_take && (item.cls == BC_NEWLINE);
  assign empty = (rcount == '0);
  assign rpop  = pop && !empty;

  assign res_in.line_selected   = line_hit ^ invert;
  assign res_in.pattern_matched = line_hit;
  assign res_in.cut_by_nul      = text_cut;

  always_ff @(posedge clk) begin
    if (rpush) begin
      rmem[rwr_ptr] <= res_in;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      rwr_ptr <= 1'b0;
      rrd_ptr <= 1'b0;
      rcount  <= '0;
    end else begin
      if (rpush) begin
        rwr_ptr <= !rwr_ptr;
      end
      if (rpop) begin
        rrd_ptr <= !rrd_ptr;
      end
      case ({rpush, rpop})
        2'b10:   rcount <= rcount + 2'd1;
        2'b01:   rcount <= rcount - 2'd1;
        default: rcount <= rcount;
      endcase
    end
  end

  assign res_out         = rmem[rrd_ptr];
  assign line_selected   = res_out.line_selected;
  assign pattern_matched = res_out.pattern_matched;
  assign cut_by_nul      = res_out.cut_by_nul;

endmodule
